// ----- rtl/msb_pkg.sv -----
// shared types and constants for the multi-stack shared buffer
`default_nettype none
package msb_pkg;

  localparam int NUM_STACKS = 8;
  localparam int CAPACITY   = 64;

  localparam int DATA_W = 32;
  localparam int SIDX_W = 3;
  // pointer holds 0..CAPACITY, CAPACITY being null
  localparam int PTR_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int HEAD_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // latch request and launch slot reads
    logic commit;  // update lists and load result register
  } msb_cmd_t;

endpackage : msb_pkg
`default_nettype wire

// ----- rtl/msb_in_if.sv -----
// request channel: valid/ready handshake with the request word
`default_nettype none
interface msb_in_if;
  import msb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [DATA_W-1:0] push_value;
  logic [SIDX_W-1:0]        stack_index;

  modport source (output valid, req_type, push_value, stack_index, input ready);
  modport sink   (input valid, req_type, push_value, stack_index, output ready);
endinterface : msb_in_if
`default_nettype wire

// ----- rtl/msb_out_if.sv -----
// result channel: valid/ready handshake with the result word
`default_nettype none
interface msb_out_if;
  import msb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     success;
  logic signed [DATA_W-1:0] pop_data;

  modport source (output valid, success, pop_data, input ready);
  modport sink   (input valid, success, pop_data, output ready);
endinterface : msb_out_if
`default_nettype wire

// ----- rtl/msb_ctrl.sv -----
// control state machine: sequences accept, commit and result handoff
`default_nettype none
module msb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output msb_pkg::msb_cmd_t     cmd
);
  import msb_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // state and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.commit    = 1'b0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // commit once the result register is free or being emptied
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule : msb_ctrl
`default_nettype wire

// ----- rtl/msb_dp.sv -----
// datapath: slot memories, stack heads, free list head and result register
`default_nettype none
module msb_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire msb_pkg::msb_cmd_t                cmd,
  input  wire logic                             req_type,
  input  wire logic signed [msb_pkg::DATA_W-1:0] push_value,
  input  wire logic [msb_pkg::SIDX_W-1:0]       stack_index,
  output logic                                  out_success,
  output logic signed [msb_pkg::DATA_W-1:0]     out_pop_data
);
  import msb_pkg::*;

  // storage
  logic [DATA_W-1:0] data_mem [CAPACITY];
  logic [PTR_W-1:0]  link_mem [CAPACITY];
  logic [CAPACITY-1:0] link_vld_r;
  logic [PTR_W-1:0]  stack_head_r [NUM_STACKS];
  logic [PTR_W-1:0]  free_head_r;

  // latched request
  logic              pop_r;
  logic [DATA_W-1:0] value_r;
  logic [HEAD_W-1:0] sidx_r;
  logic [ADDR_W-1:0] slot_r;
  logic              ok_r;
  logic [DATA_W-1:0] rd_data_r;
  logic [PTR_W-1:0]  rd_link_r;

  // result register
  logic              out_success_r;
  logic [DATA_W-1:0] out_data_r;

  logic              in_range;
  logic [PTR_W-1:0]  head_sel;
  logic [PTR_W-1:0]  slot_sel;
  logic              slot_ok;
  logic [ADDR_W-1:0] addr;
  logic              is_pop;

  // slot selection in the accept cycle
  always_comb begin
    is_pop   = (req_type == REQ_POP);
    in_range = int'(stack_index) < NUM_STACKS;
    head_sel = in_range ? stack_head_r[HEAD_W'(stack_index)] : PTR_W'(CAPACITY);
    slot_sel = is_pop ? head_sel : free_head_r;
    slot_ok  = in_range && (slot_sel < PTR_W'(CAPACITY));
    addr     = slot_sel[ADDR_W-1:0];
  end

  // request latch and registered memory reads
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pop_r     <= is_pop;
      value_r   <= push_value;
      sidx_r    <= HEAD_W'(stack_index);
      slot_r    <= addr;
      ok_r      <= slot_ok;
      rd_data_r <= data_mem[addr];
      // unwritten link entries read as their reset value, the next slot
      rd_link_r <= link_vld_r[addr] ? link_mem[addr] : PTR_W'(addr) + PTR_W'(1);
    end
  end

  // memory writes on a successful commit
  always_ff @(posedge clk) begin
    if (cmd.commit && ok_r) begin
      link_mem[slot_r] <= pop_r ? free_head_r : stack_head_r[sidx_r];
      if (!pop_r) begin
        data_mem[slot_r] <= value_r;
      end
    end
  end

  // list heads and link valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      link_vld_r  <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_head_r[i] <= PTR_W'(CAPACITY);
      end
    end else if (cmd.commit && ok_r) begin
      link_vld_r[slot_r] <= 1'b1;
      if (pop_r) begin
        stack_head_r[sidx_r] <= rd_link_r;
        free_head_r          <= PTR_W'(slot_r);
      end else begin
        stack_head_r[sidx_r] <= PTR_W'(slot_r);
        free_head_r          <= rd_link_r;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_success_r <= ok_r;
      if (ok_r) begin
        out_data_r <= pop_r ? rd_data_r : '0;
      end else begin
        out_data_r <= pop_r ? '1 : '0;
      end
    end
  end

  assign out_success  = out_success_r;
  assign out_pop_data = out_data_r;

endmodule : msb_dp
`default_nettype wire

// ----- rtl/multi_stack_shared_buffer.sv -----
// Several LIFO stacks sharing one slot store, linked through a link memory.
// The request is latched together with its slot reads, then committed into the
// result register once that register is free; a stalled result holds the next commit.
// One request is in flight at a time, set by the registered read of the
// slot link and data memories that follows the head lookup.
// Reset (synchronous, active low) clears stack heads, free head and link
// valid bits directly; no clearing pass, the block is ready right after.
`default_nettype none
module multi_stack_shared_buffer (
  input  wire logic clk,
  input  wire logic rst_n,
  msb_in_if.sink    in_ch,
  msb_out_if.source out_ch
);
  import msb_pkg::*;

  msb_cmd_t cmd;

  // control
  msb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // datapath
  msb_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .req_type     (in_ch.req_type),
    .push_value   (in_ch.push_value),
    .stack_index  (in_ch.stack_index),
    .out_success  (out_ch.success),
    .out_pop_data (out_ch.pop_data)
  );

endmodule : multi_stack_shared_buffer
`default_nettype wire

// ----- rtl/msb_checker.sv -----
// port-level checks for the multi-stack shared buffer, bound to the top level
`default_nettype none
module msb_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic                             out_success,
  input wire logic signed [msb_pkg::DATA_W-1:0] out_pop_data
);
  import msb_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a waiting result word stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_success) && $stable(out_pop_data))
    else $error("result word dropped or changed while stalled");

  // every new result follows an accepted request
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 2))
    else $error("result word without a request");

  // with the result register free, a request is answered through the request latch and the result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (!out_valid || out_ready) |-> ##2 out_valid)
    else $error("request not answered in two cycles");

  // only one request in flight
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request accepted while another is in flight");

  // a failed request reports zero data for push or all ones for pop
  a_fail_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_success |-> (out_pop_data == '0) || (out_pop_data == '1))
    else $error("failed request with bad data");

endmodule : msb_checker

bind multi_stack_shared_buffer msb_checker u_msb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_success  (out_ch.success),
  .out_pop_data (out_ch.pop_data)
);
`default_nettype wire

// ----- test/tb_top.sv -----
// testbench for multi_stack_shared_buffer: directed and random push/pop traffic against a linked-list predictor
`timescale 1ns / 1ps

module tb_top;
  import msb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MISS_SHOWN  = 10;

  typedef struct {
    req_t                     op;
    logic signed [DATA_W-1:0] value;
    logic [SIDX_W-1:0]        idx;
    bit                       quiesce;  // hold this word until all answers are back
  } stack_req_t;

  typedef struct packed {
    logic                     success;
    logic signed [DATA_W-1:0] pop_data;
  } stack_ans_t;

  logic clk;
  logic rst_n;

  msb_in_if  in_ch ();
  msb_out_if out_ch ();

  multi_stack_shared_buffer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the slot store and its lists
  logic [DATA_W-1:0] slot_val  [CAPACITY];
  logic [PTR_W-1:0]  slot_next [CAPACITY];
  logic [PTR_W-1:0]  top_of    [NUM_STACKS];
  logic [PTR_W-1:0]  free_top;

  stack_req_t req_backlog [$];
  stack_ans_t answers_due [$];

  int reqs_planned   = 0;
  int reqs_taken     = 0;
  int answers_checked = 0;
  int fail_count     = 0;
  int cycle_cnt      = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic clear_stacks();
    for (int i = 0; i < CAPACITY; i++) begin
      slot_val[i]  = '0;
      slot_next[i] = PTR_W'(i + 1);
    end
    for (int s = 0; s < NUM_STACKS; s++) top_of[s] = PTR_W'(CAPACITY);
    free_top = '0;
  endtask

  // apply one request to the shadow lists and work out its answer
  function automatic stack_ans_t apply_request(req_t op, logic [DATA_W-1:0] val,
                                               logic [SIDX_W-1:0] idx);
    stack_ans_t       ans;
    logic [PTR_W-1:0] slot;
    ans.success  = 1'b0;
    ans.pop_data = (op == REQ_POP) ? '1 : '0;
    if (int'(idx) >= NUM_STACKS) return ans;
    if (op == REQ_PUSH) begin
      if (free_top < CAPACITY) begin
        slot = free_top;
        free_top = slot_next[slot[ADDR_W-1:0]];
        slot_val[slot[ADDR_W-1:0]]  = val;
        slot_next[slot[ADDR_W-1:0]] = top_of[idx];
        top_of[idx] = slot;
        ans.success = 1'b1;
      end
    end else begin
      slot = top_of[idx];
      if (slot < CAPACITY) begin
        top_of[idx] = slot_next[slot[ADDR_W-1:0]];
        slot_next[slot[ADDR_W-1:0]] = free_top;
        free_top = slot;
        ans.success  = 1'b1;
        ans.pop_data = slot_val[slot[ADDR_W-1:0]];
      end
    end
    return ans;
  endfunction

  task automatic queue_request(req_t op, logic [DATA_W-1:0] val, logic [SIDX_W-1:0] idx,
                               bit quiesce = 1'b0);
    stack_req_t r;
    r.op      = op;
    r.value   = val;
    r.idx     = idx;
    r.quiesce = quiesce;
    req_backlog.push_back(r);
    reqs_planned++;
  endtask

  // mostly full-range values, with the extremes now and then
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // bursts that lean toward push or pop or are balanced, some confined to one or two stacks
  task automatic queue_random(int count);
    int left;
    int len;
    int pop_pct;
    int lo;
    int hi;
    left = count;
    while (left > 0) begin
      len = $urandom_range(70, 10);
      if (len > left) len = left;
      case ($urandom_range(2))
        0: pop_pct = 12;
        1: pop_pct = 88;
        default: pop_pct = 50;
      endcase
      if ($urandom_range(1) == 1) begin
        lo = $urandom_range(NUM_STACKS - 2);
        hi = lo + $urandom_range(1);
      end else begin
        lo = 0;
        hi = NUM_STACKS - 1;
      end
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(99) < pop_pct)
          queue_request(REQ_POP, $urandom(), SIDX_W'($urandom_range(hi, lo)));
        else
          queue_request(REQ_PUSH, pick_value(), SIDX_W'($urandom_range(hi, lo)));
      end
      left -= len;
    end
  endtask

  task automatic wait_drained();
    while (!(reqs_taken == reqs_planned && answers_checked == reqs_taken))
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic report_miss(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    fail_count++;
    if (fail_count <= MISS_SHOWN)
      $display("%s mismatch at answer %0d: expected %h got %h", field, answers_checked,
               want, got);
  endtask

  // request driver
  always @(posedge clk) begin : request_driver
    stack_req_t nxt;
    bit         taking;
    bit         drained;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      taking = in_ch.valid && in_ch.ready;
      if (taking) begin
        answers_due.push_back(apply_request(req_t'(in_ch.req_type), in_ch.push_value,
                                            in_ch.stack_index));
        reqs_taken <= reqs_taken + 1;
      end
      drained = !taking && (reqs_taken == answers_checked);
      if (!in_ch.valid || in_ch.ready) begin
        if (req_backlog.size() != 0 && !(req_backlog[0].quiesce && !drained) &&
            $urandom_range(99) >= send_idle_pct) begin
          nxt = req_backlog.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.req_type    <= nxt.op;
          in_ch.push_value  <= nxt.value;
          in_ch.stack_index <= nxt.idx;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // answer monitor
  always @(posedge clk) begin : answer_monitor
    stack_ans_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (answers_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MISS_SHOWN)
            $display("unexpected answer: success %b pop_data %h", out_ch.success,
                     out_ch.pop_data);
        end else begin
          want = answers_due.pop_front();
          if (out_ch.success !== want.success)
            report_miss("success", DATA_W'(want.success), DATA_W'(out_ch.success));
          if (out_ch.pop_data !== want.pop_data)
            report_miss("pop_data", want.pop_data, out_ch.pop_data);
          answers_checked <= answers_checked + 1;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // reset, stimulus and final verdict
  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_PUSH;
    in_ch.push_value  = '0;
    in_ch.stack_index = '0;
    out_ch.ready      = 1'b0;
    clear_stacks();
    send_idle_pct = 14;
    recv_idle_pct = 70;

    // directed: empty pops, extreme values, lifo order, emptied stacks
    queue_request(REQ_POP,  32'h1234_5678, 3'd0);
    queue_request(REQ_POP,  32'hffff_ffff, 3'd7);
    queue_request(REQ_PUSH, 32'h7fff_ffff, 3'd0);
    queue_request(REQ_PUSH, 32'h8000_0000, 3'd0);
    queue_request(REQ_PUSH, 32'h0000_0000, 3'd0);
    queue_request(REQ_PUSH, 32'hffff_ffff, 3'd0);
    queue_request(REQ_PUSH, 32'h0000_0001, 3'd7);
    queue_request(REQ_PUSH, 32'h5555_5555, 3'd3);
    queue_request(REQ_PUSH, 32'haaaa_aaaa, 3'd3);
    for (int k = 0; k < 5; k++) queue_request(REQ_POP, $urandom(), 3'd0);
    queue_request(REQ_POP, $urandom(), 3'd7);
    queue_request(REQ_POP, $urandom(), 3'd3);
    queue_request(REQ_POP, $urandom(), 3'd3);
    queue_request(REQ_POP, $urandom(), 3'd3);
    queue_request(REQ_POP, $urandom(), 3'd7);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // sender rarely idle, receiver mostly stalled; start with a fill past full and a drain
    for (int k = 0; k < 70; k++)
      queue_request(REQ_PUSH, pick_value(), SIDX_W'($urandom_range(NUM_STACKS - 1)), k == 0);
    for (int k = 0; k < 70; k++)
      queue_request(REQ_POP, $urandom(), SIDX_W'($urandom_range(NUM_STACKS - 1)));
    queue_random(410);
    wait_drained();

    // sender mostly idle, receiver rarely stalled
    send_idle_pct = 70;
    recv_idle_pct = 14;
    queue_random(550);
    wait_drained();

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(550);
    wait_drained();

    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/msb_pkg.sv
rtl/msb_in_if.sv
rtl/msb_out_if.sv
rtl/msb_ctrl.sv
rtl/msb_dp.sv
rtl/multi_stack_shared_buffer.sv
rtl/msb_checker.sv
test/tb_top.sv
